@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication on every rising clock edge outside reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/dttr_pkg.sv @@
// ----------------------------------------------------------------------------
// dttr_pkg
// Shared types and constants of the depth tested triangle rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dttr_pkg;

  localparam int CW          = 13;  // vertex coordinate width
  localparam int DEPTH_W     = 16;
  localparam int COLOR_W     = 24;
  localparam int COUNT_W     = 13;
  localparam int IDX_W       = 12;
  localparam int OP_W        = 2;
  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 56;

  localparam int WIDTH_DEF         = 64;
  localparam int HEIGHT_DEF        = 64;
  localparam int FRACTION_BITS_DEF = 4;

  localparam logic [DEPTH_W-1:0] FAR_DEPTH = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_DRAW  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SETUP,
    S_FIN,
    S_NORM,
    S_PIX,
    S_MUL,
    S_DIV,
    S_TEST,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

@@ rtl/depth_tested_triangle_rasterizer.sv @@
// ----------------------------------------------------------------------------
// depth_tested_triangle_rasterizer
// Triangle rasterizer with a colour store and a depth store in block RAM.
// ----------------------------------------------------------------------------
// One transaction at a time. A draw first forms the setup products, then
// steps through every screen pixel in raster order; a pixel inside the
// triangle takes a depth read, three weight multiplies, a 16-step restoring
// divide, a compare and, when it passes, a write back; then the draw posts
// the result. A clear writes every pixel through the single write port of
// the stores. A result that is still waiting in the output register holds
// the next one back. After reset the block clears the stores before
// in_tready rises.
`timescale 1ns / 1ps
`default_nettype none
module depth_tested_triangle_rasterizer
  import dttr_pkg::*;
#(
  parameter int WIDTH         = WIDTH_DEF,
  parameter int HEIGHT        = HEIGHT_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // operation, a_x, a_y, b_x, b_y, c_x, c_y, a_depth, b_depth, c_depth,
  // paint_color, pixel_index
  input  wire [IN_TDATA_W-1:0]   in_tdata,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  // read_color, read_depth, pixels_written
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int PIX  = WIDTH * HEIGHT;
  localparam int ADW  = (PIX > 1) ? $clog2(PIX) : 1;
  localparam int CNTW = $clog2(PIX + 1);
  localparam int XW   = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int YW   = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
  localparam int MW   = (WIDTH > HEIGHT) ? WIDTH : HEIGHT;
  localparam int DW   = CW + 2;                  // coordinate difference
  localparam int PW   = 2 * DW;                  // setup product
  localparam int AW   = PW + 1;                  // doubled area
  localparam int EW   = PW + $clog2(MW + 1) + FRACTION_BITS + 4;
  localparam int NW   = AW + DEPTH_W + 2;        // weighted depth sum
  localparam int QW   = $clog2(DEPTH_W + 1);

  // ---------------------------------------------------------------- fields
  logic [OP_W-1:0]    f_op;
  logic [CW-1:0]      f_ax, f_ay, f_bx, f_by, f_cx, f_cy;
  logic [DEPTH_W-1:0] f_da, f_db, f_dc;
  logic [COLOR_W-1:0] f_color;
  logic [IDX_W-1:0]   f_idx;

  assign f_op    = in_tdata[1:0];
  assign f_ax    = in_tdata[14:2];
  assign f_ay    = in_tdata[27:15];
  assign f_bx    = in_tdata[40:28];
  assign f_by    = in_tdata[53:41];
  assign f_cx    = in_tdata[66:54];
  assign f_cy    = in_tdata[79:67];
  assign f_da    = in_tdata[95:80];
  assign f_db    = in_tdata[111:96];
  assign f_dc    = in_tdata[127:112];
  assign f_color = in_tdata[151:128];
  assign f_idx   = in_tdata[163:152];

  // ---------------------------------------------------------------- state
  state_t                state_r, state_nxt;
  logic                  init_r, init_nxt;
  logic signed [CW-1:0]  ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic signed [CW-1:0]  ax_nxt, ay_nxt, bx_nxt, by_nxt, cx_nxt, cy_nxt;
  logic [DEPTH_W-1:0]    da_r, db_r, dc_r, da_nxt, db_nxt, dc_nxt;
  logic [COLOR_W-1:0]    color_r, color_nxt;
  logic [CNTW-1:0]       clr_r, clr_nxt;
  logic [2:0]            scnt_r, scnt_nxt;
  logic signed [PW-1:0]  p_r [8];
  logic signed [PW-1:0]  p_nxt [8];
  logic [AW-1:0]         area_r, area_nxt;
  logic signed [EW-1:0]  e_r [3];
  logic signed [EW-1:0]  e_nxt [3];
  logic signed [EW-1:0]  row_r [3];
  logic signed [EW-1:0]  row_nxt [3];
  logic signed [EW-1:0]  sx_r [3];
  logic signed [EW-1:0]  sx_nxt [3];
  logic signed [EW-1:0]  sy_r [3];
  logic signed [EW-1:0]  sy_nxt [3];
  logic [XW-1:0]         x_r, x_nxt;
  logic [YW-1:0]         y_r, y_nxt;
  logic [ADW-1:0]        addr_r, addr_nxt;
  logic [1:0]            mcnt_r, mcnt_nxt;
  logic [AW+DEPTH_W-1:0] prod_r, prod_nxt;
  logic [NW-1:0]         num_r, num_nxt;
  logic [AW-1:0]         rem_r, rem_nxt;
  logic [DEPTH_W-1:0]    quo_r, quo_nxt;
  logic [QW-1:0]         dcnt_r, dcnt_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [COLOR_W-1:0]    res_color_r, res_color_nxt;
  logic [DEPTH_W-1:0]    res_depth_r, res_depth_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // memory ports
  logic                  mem_we, mem_re;
  logic [ADW-1:0]        mem_waddr, mem_raddr;
  logic [COLOR_W-1:0]    mem_wcolor;
  logic [DEPTH_W-1:0]    mem_wdepth;
  logic [COLOR_W-1:0]    rd_color_r;
  logic [DEPTH_W-1:0]    rd_depth_r;
  logic [COLOR_W-1:0]    color_mem [PIX];
  logic [DEPTH_W-1:0]    depth_mem [PIX];

  // ------------------------------------------------------------ datapath
  logic signed [DW-1:0]  d_bax, d_cay, d_bay, d_cax, d_cby, d_cbx, d_acy, d_acx;
  logic signed [DW-1:0]  s_op_a, s_op_b;
  logic signed [AW-1:0]  area_s;
  logic [AW-1:0]         w_sel;
  logic [DEPTH_W-1:0]    dep_sel;
  logic [NW-1:0]         num_sum;
  logic [AW:0]           rem_try;
  logic                  in_tri, last_pix, advance;

  assign d_bax = DW'(bx_r) - DW'(ax_r);
  assign d_bay = DW'(by_r) - DW'(ay_r);
  assign d_cax = DW'(cx_r) - DW'(ax_r);
  assign d_cay = DW'(cy_r) - DW'(ay_r);
  assign d_cbx = DW'(cx_r) - DW'(bx_r);
  assign d_cby = DW'(cy_r) - DW'(by_r);
  assign d_acx = DW'(ax_r) - DW'(cx_r);
  assign d_acy = DW'(ay_r) - DW'(cy_r);

  // Select the operands of the shared setup multiplier
  always_comb begin
    case (scnt_r)
      3'd0: begin s_op_a = d_bax; s_op_b = d_cay; end
      3'd1: begin s_op_a = d_bay; s_op_b = d_cax; end
      3'd2: begin s_op_a = d_cby; s_op_b = DW'(bx_r); end
      3'd3: begin s_op_a = d_cbx; s_op_b = DW'(by_r); end
      3'd4: begin s_op_a = d_acy; s_op_b = DW'(cx_r); end
      3'd5: begin s_op_a = d_acx; s_op_b = DW'(cy_r); end
      3'd6: begin s_op_a = d_bay; s_op_b = DW'(ax_r); end
      default: begin s_op_a = d_bax; s_op_b = DW'(ay_r); end
    endcase
  end

  // Select weight and vertex depth for the per-pixel multiplier
  always_comb begin
    case (mcnt_r)
      2'd0: begin w_sel = AW'(e_r[0]); dep_sel = da_r; end
      2'd1: begin w_sel = AW'(e_r[1]); dep_sel = db_r; end
      default: begin w_sel = AW'(e_r[2]); dep_sel = dc_r; end
    endcase
  end

  assign area_s   = AW'(p_r[0]) - AW'(p_r[1]);
  assign num_sum  = num_r + NW'(prod_r);
  assign rem_try  = {rem_r, quo_r[DEPTH_W-1]};
  assign in_tri   = !e_r[0][EW-1] && !e_r[1][EW-1] && !e_r[2][EW-1];
  assign last_pix = (x_r == XW'(WIDTH - 1)) && (y_r == YW'(HEIGHT - 1));

  // ---------------------------------------------------------- next state
  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    ax_nxt = ax_r; ay_nxt = ay_r; bx_nxt = bx_r;
    by_nxt = by_r; cx_nxt = cx_r; cy_nxt = cy_r;
    da_nxt = da_r; db_nxt = db_r; dc_nxt = dc_r;
    color_nxt     = color_r;
    clr_nxt       = clr_r;
    scnt_nxt      = scnt_r;
    p_nxt         = p_r;
    area_nxt      = area_r;
    e_nxt         = e_r;
    row_nxt       = row_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    addr_nxt      = addr_r;
    mcnt_nxt      = mcnt_r;
    prod_nxt      = prod_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dcnt_nxt      = dcnt_r;
    count_nxt     = count_r;
    res_color_nxt = res_color_r;
    res_depth_nxt = res_depth_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_tready     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wcolor    = color_r;
    mem_wdepth    = FAR_DEPTH;
    mem_re        = 1'b0;
    mem_raddr     = addr_r;
    advance       = 1'b0;

    // drop the result once it is taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r[ADW-1:0];
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == CNTW'(PIX - 1)) begin
          state_nxt = init_r ? S_IDLE : S_DONE;
          init_nxt  = 1'b0;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ax_nxt = f_ax; ay_nxt = f_ay; bx_nxt = f_bx;
          by_nxt = f_by; cx_nxt = f_cx; cy_nxt = f_cy;
          da_nxt = f_da; db_nxt = f_db; dc_nxt = f_dc;
          color_nxt     = f_color;
          count_nxt     = '0;
          res_color_nxt = '0;
          res_depth_nxt = '0;
          scnt_nxt      = '0;
          clr_nxt       = '0;
          case (op_t'(f_op))
            OP_DRAW:  state_nxt = S_SETUP;
            OP_READ: begin
              if (32'(f_idx) < 32'(PIX)) begin
                mem_re    = 1'b1;
                mem_raddr = ADW'(f_idx);
                state_nxt = S_READ;
              end else begin
                state_nxt = S_DONE;
              end
            end
            OP_CLEAR: state_nxt = S_CLEAR;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_READ: begin
        res_color_nxt = rd_color_r;
        res_depth_nxt = rd_depth_r;
        state_nxt     = S_DONE;
      end
      S_SETUP: begin
        p_nxt[scnt_r] = PW'(s_op_a * s_op_b);
        scnt_nxt      = scnt_r + 1'b1;
        if (scnt_r == 3'd7) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // edge values at the origin and their per-pixel steps
        area_nxt   = area_s;
        e_nxt[0]   = EW'(p_r[2]) - EW'(p_r[3]);
        e_nxt[1]   = EW'(p_r[4]) - EW'(p_r[5]);
        e_nxt[2]   = EW'(p_r[6]) - EW'(p_r[7]);
        row_nxt[0] = EW'(p_r[2]) - EW'(p_r[3]);
        row_nxt[1] = EW'(p_r[4]) - EW'(p_r[5]);
        row_nxt[2] = EW'(p_r[6]) - EW'(p_r[7]);
        sx_nxt[0]  = -(EW'(d_cby) <<< FRACTION_BITS);
        sx_nxt[1]  = -(EW'(d_acy) <<< FRACTION_BITS);
        sx_nxt[2]  = -(EW'(d_bay) <<< FRACTION_BITS);
        sy_nxt[0]  = EW'(d_cbx) <<< FRACTION_BITS;
        sy_nxt[1]  = EW'(d_acx) <<< FRACTION_BITS;
        sy_nxt[2]  = EW'(d_bax) <<< FRACTION_BITS;
        state_nxt  = (area_s == '0) ? S_DONE : S_NORM;
      end
      S_NORM: begin
        // flip clockwise triangles so that inside means all edges >= 0
        if (area_r[AW-1]) begin
          area_nxt = -area_r;
          for (int k = 0; k < 3; k++) begin
            e_nxt[k]   = -e_r[k];
            row_nxt[k] = -row_r[k];
            sx_nxt[k]  = -sx_r[k];
            sy_nxt[k]  = -sy_r[k];
          end
        end
        x_nxt     = '0;
        y_nxt     = '0;
        addr_nxt  = '0;
        state_nxt = S_PIX;
      end
      S_PIX: begin
        if (in_tri) begin
          mem_re    = 1'b1;
          mcnt_nxt  = '0;
          num_nxt   = '0;
          state_nxt = S_MUL;
        end else begin
          advance = 1'b1;
        end
      end
      S_MUL: begin
        prod_nxt = (AW + DEPTH_W)'(w_sel * dep_sel);
        mcnt_nxt = mcnt_r + 1'b1;
        if (mcnt_r != 2'd0) begin
          num_nxt = num_sum;
        end
        if (mcnt_r == 2'd3) begin
          rem_nxt   = AW'(num_sum >> DEPTH_W);
          quo_nxt   = num_sum[DEPTH_W-1:0];
          dcnt_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // one restoring step: quotient bits shift in where dividend bits leave
        if (rem_try >= {1'b0, area_r}) begin
          rem_nxt = AW'(rem_try - {1'b0, area_r});
          quo_nxt = {quo_r[DEPTH_W-2:0], 1'b1};
        end else begin
          rem_nxt = AW'(rem_try);
          quo_nxt = {quo_r[DEPTH_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == QW'(DEPTH_W - 1)) begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (quo_r < rd_depth_r) begin
          mem_we     = 1'b1;
          mem_wdepth = quo_r;
          if (count_r != COUNT_MAX) begin
            count_nxt = count_r + 1'b1;
          end
        end
        advance = 1'b1;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b0, count_r, res_depth_r, res_color_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // step to the next pixel in raster order
    if (advance) begin
      addr_nxt = addr_r + 1'b1;
      if (last_pix) begin
        state_nxt = S_DONE;
      end else if (x_r == XW'(WIDTH - 1)) begin
        x_nxt     = '0;
        y_nxt     = y_r + 1'b1;
        state_nxt = S_PIX;
        for (int k = 0; k < 3; k++) begin
          row_nxt[k] = row_r[k] + sy_r[k];
          e_nxt[k]   = row_r[k] + sy_r[k];
        end
      end else begin
        x_nxt     = x_r + 1'b1;
        state_nxt = S_PIX;
        for (int k = 0; k < 3; k++) begin
          e_nxt[k] = e_r[k] + sx_r[k];
        end
      end
    end
  end

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      init_r      <= 1'b1;
      clr_r       <= '0;
      color_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      clr_r       <= clr_nxt;
      color_r     <= color_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ax_r <= ax_nxt; ay_r <= ay_nxt; bx_r <= bx_nxt;
    by_r <= by_nxt; cx_r <= cx_nxt; cy_r <= cy_nxt;
    da_r <= da_nxt; db_r <= db_nxt; dc_r <= dc_nxt;
    scnt_r      <= scnt_nxt;
    p_r         <= p_nxt;
    area_r      <= area_nxt;
    e_r         <= e_nxt;
    row_r       <= row_nxt;
    sx_r        <= sx_nxt;
    sy_r        <= sy_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    addr_r      <= addr_nxt;
    mcnt_r      <= mcnt_nxt;
    prod_r      <= prod_nxt;
    num_r       <= num_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    dcnt_r      <= dcnt_nxt;
    count_r     <= count_nxt;
    res_color_r <= res_color_nxt;
    res_depth_r <= res_depth_nxt;
    out_data_r  <= out_data_nxt;
  end

  // ------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (mem_we) begin
      color_mem[mem_waddr] <= mem_wcolor;
      depth_mem[mem_waddr] <= mem_wdepth;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_color_r <= color_mem[mem_raddr];
      rd_depth_r <= depth_mem[mem_raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ----------------------------------------------------------- assertions
  `include "assert_macros.svh"

  `ASSERT_IMP(a_div_rem, state_r == S_DIV, rem_r < area_r, "divider remainder not below area")
  `ASSERT_IMP(a_test_write, mem_we && state_r == S_TEST, quo_r < rd_depth_r, "depth write without passing test")
  `ASSERT_CLK(a_count_up, state_r == S_TEST |=> count_r >= $past(count_r), "written count went down")

endmodule
`default_nettype wire
